// ----- hw/rtl/mbpg_pkg.sv -----
package mbpg_pkg;

    typedef struct packed {
        logic [1:0]  pool_enables;
        logic [15:0] texture_fraction;
        logic [27:0] texture_manual_mb;
        logic [27:0] texture_min_mb;
        logic [15:0] mesh_share;
        logic [27:0] mesh_manual_mb;
        logic [27:0] mesh_min_mb;
        logic [27:0] rsv_mb;
    } t_cfg;

    localparam logic [2:0] REG_POOL_ENABLES      = 3'd0;
    localparam logic [2:0] REG_TEXTURE_FRACTION  = 3'd1;
    localparam logic [2:0] REG_TEXTURE_MANUAL_MB = 3'd2;
    localparam logic [2:0] REG_TEXTURE_MIN_MB    = 3'd3;
    localparam logic [2:0] REG_MESH_SHARE        = 3'd4;
    localparam logic [2:0] REG_MESH_MANUAL_MB    = 3'd5;
    localparam logic [2:0] REG_MESH_MIN_MB       = 3'd6;
    localparam logic [2:0] REG_RSV_MB            = 3'd7;

    localparam logic [15:0] TEX_FRAC_MIN  = 16'd3277;
    localparam logic [15:0] TEX_FRAC_MAX  = 16'd58982;
    localparam logic [15:0] MESH_FRAC_MIN = 16'd655;
    localparam logic [15:0] MESH_FRAC_MAX = 16'd32768;

    localparam logic [47:0] GIB_BYTES = 48'h0000_4000_0000;

    localparam logic [1:0] LVL_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_SOFT     = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd2;

endpackage

// ----- hw/rtl/mbpg_regs.sv -----
module mbpg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output mbpg_pkg::t_cfg       o_cfg
);

    mbpg_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_enables      <= 2'd3;
            r_cfg.texture_fraction  <= 16'd32768;
            r_cfg.texture_manual_mb <= 28'd0;
            r_cfg.texture_min_mb    <= 28'd1024;
            r_cfg.mesh_share        <= 16'd6554;
            r_cfg.mesh_manual_mb    <= 28'd0;
            r_cfg.mesh_min_mb       <= 28'd256;
            r_cfg.rsv_mb            <= 28'd6144;
        end else if (w_wr) begin
            unique case (w_idx)
                mbpg_pkg::REG_POOL_ENABLES:      r_cfg.pool_enables      <= pwdata[1:0];
                mbpg_pkg::REG_TEXTURE_FRACTION:  r_cfg.texture_fraction  <= pwdata[15:0];
                mbpg_pkg::REG_TEXTURE_MANUAL_MB: r_cfg.texture_manual_mb <= pwdata[27:0];
                mbpg_pkg::REG_TEXTURE_MIN_MB:    r_cfg.texture_min_mb    <= pwdata[27:0];
                mbpg_pkg::REG_MESH_SHARE:        r_cfg.mesh_share        <= pwdata[15:0];
                mbpg_pkg::REG_MESH_MANUAL_MB:    r_cfg.mesh_manual_mb    <= pwdata[27:0];
                mbpg_pkg::REG_MESH_MIN_MB:       r_cfg.mesh_min_mb       <= pwdata[27:0];
                mbpg_pkg::REG_RSV_MB:            r_cfg.rsv_mb            <= pwdata[27:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mbpg_pkg::REG_POOL_ENABLES:      prdata = {30'd0, r_cfg.pool_enables};
            mbpg_pkg::REG_TEXTURE_FRACTION:  prdata = {16'd0, r_cfg.texture_fraction};
            mbpg_pkg::REG_TEXTURE_MANUAL_MB: prdata = {4'd0, r_cfg.texture_manual_mb};
            mbpg_pkg::REG_TEXTURE_MIN_MB:    prdata = {4'd0, r_cfg.texture_min_mb};
            mbpg_pkg::REG_MESH_SHARE:        prdata = {16'd0, r_cfg.mesh_share};
            mbpg_pkg::REG_MESH_MANUAL_MB:    prdata = {4'd0, r_cfg.mesh_manual_mb};
            mbpg_pkg::REG_MESH_MIN_MB:       prdata = {4'd0, r_cfg.mesh_min_mb};
            mbpg_pkg::REG_RSV_MB:            prdata = {4'd0, r_cfg.rsv_mb};
            default:                         prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/mbpg_mul.sv -----
module mbpg_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_x,
    input  logic [15:0] i_m,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [47:0] r_x;
    logic [15:0] r_m;
    logic [63:0] r_acc;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_m   <= i_m;
            r_acc <= 64'd0;
        end else if (r_busy) begin
            r_acc <= {r_acc[62:0], 1'b0} + (r_m[15] ? {16'd0, r_x} : 64'd0);
            r_m   <= {r_m[14:0], 1'b0};
        end
    end

endmodule

// ----- hw/rtl/mbpg_muldiv.sv -----
module mbpg_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_a,
    input  logic [47:0] i_b,
    input  logic [48:0] i_c,
    output logic        o_done,
    output logic [48:0] o_quot
);

    logic [48:0] r_a;
    logic [47:0] r_b;
    logic [48:0] r_c;
    logic [50:0] r_r;
    logic [48:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_phase;
    logic        r_busy;
    logic        r_done;
    logic [51:0] w_d1;
    logic [51:0] w_d2;
    logic [1:0]  w_k;
    logic [50:0] w_rn;

    assign o_done = r_done;
    assign o_quot = r_q;

    assign w_d1 = {1'b0, r_r} - {3'b0, r_c};
    assign w_d2 = {1'b0, r_r} - {2'b0, r_c, 1'b0};

    always_comb begin
        if (!w_d2[51]) begin
            w_k  = 2'd2;
            w_rn = w_d2[50:0];
        end else if (!w_d1[51]) begin
            w_k  = 2'd1;
            w_rn = w_d1[50:0];
        end else begin
            w_k  = 2'd0;
            w_rn = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= 6'd48;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
            r_r <= 51'd0;
            r_q <= 49'd0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_r <= {r_r[49:0], 1'b0} + (r_a[48] ? {3'b0, r_b} : 51'd0);
                r_a <= {r_a[47:0], 1'b0};
            end else begin
                r_r <= w_rn;
                r_q <= {r_q[47:0], 1'b0} + {47'd0, w_k};
            end
        end
    end

endmodule

// ----- hw/rtl/memory_budget_pressure_governor.sv -----
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready  installed, available, low flag, pool sizes
// result    out        o_out_valid / i_out_ready budgets, pressure, inserts flag, reserve
// config    in         psel / penable / pready  paddr, pwdata, prdata
// One item is handled at a time: the input is ready again in the same cycle that its
// result becomes valid. Up to two waits on the bit-serial multiply-divide unit and
// three waits on the serial multiplier take most of the time from acceptance to result.
// Each divide is skipped when it has nothing to do.
// Reset is synchronous and returns the pressure level to normal.
// A finished result waits in the output register while the next item is taken; a new
// result that finds it still occupied holds the block in its last state.
module memory_budget_pressure_governor #(
    parameter int RESERVE_FRACTION_Q16 = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [37:0] i_installed_kib,
    input  logic [37:0] i_effective_available_kib,
    input  logic        i_system_low_flag,
    input  logic [47:0] i_texture_pool_bytes,
    input  logic [47:0] i_mesh_pool_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_tex_grant_bytes,
    output logic [47:0] o_mesh_grant_bytes,
    output logic [1:0]  o_pressure_out,
    output logic        o_insert_ok,
    output logic [47:0] o_reserve_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RF_CLAMPED = (RESERVE_FRACTION_Q16 < 6554) ? 6554 :
                                ((RESERVE_FRACTION_Q16 > 32768) ? 32768 : RESERVE_FRACTION_Q16);
    localparam logic [15:0] RES_FRAC = 16'(RF_CLAMPED);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RES  = 4'd1;
    localparam logic [3:0] S_MULR = 4'd2;
    localparam logic [3:0] S_USE  = 4'd3;
    localparam logic [3:0] S_TST  = 4'd4;
    localparam logic [3:0] S_MULT = 4'd5;
    localparam logic [3:0] S_MST  = 4'd6;
    localparam logic [3:0] S_MULM = 4'd7;
    localparam logic [3:0] S_TOT  = 4'd8;
    localparam logic [3:0] S_CHK  = 4'd9;
    localparam logic [3:0] S_DIV1 = 4'd10;
    localparam logic [3:0] S_CMB  = 4'd11;
    localparam logic [3:0] S_D2S  = 4'd12;
    localparam logic [3:0] S_DIV2 = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    mbpg_pkg::t_cfg w_cfg;

    logic [3:0]  r_state;
    logic [1:0]  r_plevel;
    logic [47:0] r_inst;
    logic [47:0] r_eff;
    logic        r_low;
    logic [47:0] r_tpool;
    logic [47:0] r_mpool;
    logic [47:0] r_absf;
    logic [47:0] r_res;
    logic [47:0] r_use;
    logic [47:0] r_dtex;
    logic [47:0] r_dmesh;
    logic [48:0] r_dtot;
    logic [49:0] r_live;
    logic [48:0] r_comb;
    logic [47:0] r_crit;
    logic [48:0] r_critm;
    logic [48:0] r_resm;
    logic [47:0] r_texb;
    logic [47:0] r_meshb;
    logic        r_ovalid;
    logic [47:0] r_otex;
    logic [47:0] r_omesh;
    logic [1:0]  r_opress;
    logic [47:0] r_ores;

    logic        w_mul_start;
    logic [47:0] w_mul_x;
    logic [15:0] w_mul_m;
    logic        w_mul_done;
    logic [63:0] w_mul_p;
    logic        w_div_start;
    logic [48:0] w_div_a;
    logic        w_div_done;
    logic [48:0] w_div_q;
    logic [15:0] w_tfrac;
    logic [15:0] w_mfrac;
    logic [47:0] w_fracf;
    logic [47:0] w_absmb;
    logic [50:0] w_live;
    logic [47:0] w_margin;
    logic [47:0] w_half;
    logic [48:0] w_qsel;
    logic [48:0] w_mrest;
    logic [1:0]  n_plevel;
    logic        w_out_free;

    function automatic logic [47:0] f_desired(logic a_en, logic [27:0] a_man,
                                              logic [27:0] a_flo, logic [47:0] a_prod,
                                              logic [47:0] a_usable);
        logic [47:0] d;
        logic [47:0] fl;
        d  = (a_man != 28'd0) ? {a_man, 20'd0} : a_prod;
        fl = {a_flo, 20'd0};
        if (d < fl) d = fl;
        if (d > a_usable) d = a_usable;
        if (!a_en || a_usable == 48'd0) d = 48'd0;
        return d;
    endfunction

    mbpg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_tfrac = (w_cfg.texture_fraction < mbpg_pkg::TEX_FRAC_MIN) ? mbpg_pkg::TEX_FRAC_MIN :
                     ((w_cfg.texture_fraction > mbpg_pkg::TEX_FRAC_MAX) ?
                      mbpg_pkg::TEX_FRAC_MAX : w_cfg.texture_fraction);
    assign w_mfrac = (w_cfg.mesh_share < mbpg_pkg::MESH_FRAC_MIN) ? mbpg_pkg::MESH_FRAC_MIN :
                     ((w_cfg.mesh_share > mbpg_pkg::MESH_FRAC_MAX) ?
                      mbpg_pkg::MESH_FRAC_MAX : w_cfg.mesh_share);

    assign w_mul_start = (r_state == S_RES) || (r_state == S_TST) || (r_state == S_MST);
    assign w_mul_x     = (r_state == S_RES) ? r_inst : r_use;
    assign w_mul_m     = (r_state == S_RES) ? RES_FRAC :
                         ((r_state == S_TST) ? w_tfrac : w_mfrac);

    mbpg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_mul_x),
        .i_m     (w_mul_m),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_p)
    );

    assign w_div_start = ((r_state == S_CHK) && (r_dtot > {1'b0, r_use})) ||
                         ((r_state == S_D2S) && (r_dtot != 49'd0));
    assign w_div_a     = (r_state == S_CHK) ? {1'b0, r_use} : r_comb;

    mbpg_muldiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (w_div_a),
        .i_b     (r_dtex),
        .i_c     (r_dtot),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    assign w_fracf  = w_mul_p[63:16];
    assign w_absmb  = {w_cfg.rsv_mb, 20'd0};
    assign w_live   = {3'd0, r_tpool} + {3'd0, r_mpool} + {3'd0, r_eff} - {3'd0, r_res};
    assign w_half   = (r_res[47:1] > mbpg_pkg::GIB_BYTES[46:0]) ? {1'b0, r_res[47:1]} :
                      mbpg_pkg::GIB_BYTES;
    assign w_margin = (r_res[47:3] > mbpg_pkg::GIB_BYTES[44:0]) ? {3'd0, r_res[47:3]} :
                      mbpg_pkg::GIB_BYTES;
    assign w_qsel   = (r_dtot == 49'd0) ? 49'd0 : w_div_q;
    assign w_mrest  = r_comb - w_qsel;

    always_comb begin
        if (r_low || (r_eff < r_crit)) begin
            n_plevel = mbpg_pkg::LVL_CRITICAL;
        end else if ((r_plevel == mbpg_pkg::LVL_CRITICAL) && ({1'b0, r_eff} < r_critm)) begin
            n_plevel = mbpg_pkg::LVL_CRITICAL;
        end else if (r_eff < r_res) begin
            n_plevel = mbpg_pkg::LVL_SOFT;
        end else if ((r_plevel == mbpg_pkg::LVL_SOFT) && ({1'b0, r_eff} < r_resm)) begin
            n_plevel = mbpg_pkg::LVL_SOFT;
        end else begin
            n_plevel = mbpg_pkg::LVL_NORMAL;
        end
    end

    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_plevel <= mbpg_pkg::LVL_NORMAL;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= ((r_state == S_DONE) && w_out_free) || (r_ovalid && !i_out_ready);
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_RES;
                S_RES:  r_state <= S_MULR;
                S_MULR: if (w_mul_done) r_state <= S_USE;
                S_USE:  r_state <= S_TST;
                S_TST:  r_state <= S_MULT;
                S_MULT: if (w_mul_done) r_state <= S_MST;
                S_MST:  r_state <= S_MULM;
                S_MULM: if (w_mul_done) r_state <= S_TOT;
                S_TOT:  r_state <= S_CHK;
                S_CHK:  r_state <= w_div_start ? S_DIV1 : S_CMB;
                S_DIV1: if (w_div_done) r_state <= S_CMB;
                S_CMB:  r_state <= S_D2S;
                S_D2S:  r_state <= w_div_start ? S_DIV2 : S_DONE;
                S_DIV2: if (w_div_done) r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_plevel <= n_plevel;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_inst  <= {i_installed_kib, 10'd0};
                    r_eff   <= {i_effective_available_kib, 10'd0};
                    r_low   <= i_system_low_flag;
                    r_tpool <= i_texture_pool_bytes;
                    r_mpool <= i_mesh_pool_bytes;
                end
            end
            S_RES: r_absf <= (w_absmb > {1'b0, r_inst[47:1]}) ? {1'b0, r_inst[47:1]} : w_absmb;
            S_MULR: if (w_mul_done) r_res <= (r_absf > w_fracf) ? r_absf : w_fracf;
            S_USE: r_use <= (r_inst > r_res) ? (r_inst - r_res) : 48'd0;
            S_MULT: begin
                if (w_mul_done) begin
                    r_dtex <= f_desired(w_cfg.pool_enables[0], w_cfg.texture_manual_mb,
                                        w_cfg.texture_min_mb, w_fracf, r_use);
                end
            end
            S_MULM: begin
                if (w_mul_done) begin
                    r_dmesh <= f_desired(w_cfg.pool_enables[1], w_cfg.mesh_manual_mb,
                                         w_cfg.mesh_min_mb, w_fracf, r_use);
                end
            end
            S_TOT: begin
                r_dtot  <= {1'b0, r_dtex} + {1'b0, r_dmesh};
                r_live  <= w_live[50] ? 50'd0 : w_live[49:0];
                r_crit  <= w_half;
                r_critm <= {1'b0, w_half} + {1'b0, w_margin};
                r_resm  <= {1'b0, r_res} + {1'b0, w_margin};
            end
            S_DIV1: begin
                if (w_div_done) begin
                    r_dtex  <= w_div_q[47:0];
                    r_dmesh <= r_use - w_div_q[47:0];
                    r_dtot  <= {1'b0, r_use};
                end
            end
            S_CMB: r_comb <= ({1'b0, r_dtot} < r_live) ? r_dtot : r_live[48:0];
            S_D2S, S_DIV2: begin
                if (!w_cfg.pool_enables[1]) begin
                    r_texb  <= r_comb[47:0];
                    r_meshb <= 48'd0;
                end else if (!w_cfg.pool_enables[0]) begin
                    r_texb  <= 48'd0;
                    r_meshb <= r_comb[47:0];
                end else begin
                    r_texb  <= w_qsel[47:0];
                    r_meshb <= w_mrest[47:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_otex   <= r_texb;
                    r_omesh  <= r_meshb;
                    r_opress <= n_plevel;
                    r_ores   <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_ovalid;
    assign o_tex_grant_bytes  = r_otex;
    assign o_mesh_grant_bytes = r_omesh;
    assign o_pressure_out     = r_opress;
    assign o_insert_ok        = (r_opress == mbpg_pkg::LVL_NORMAL);
    assign o_reserve_bytes    = r_ores;

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MULR || r_state == S_MULT || r_state == S_MULM))
        else $error("multiplier finished outside a wait state");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside a wait state");

    a_level_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plevel != 2'd3)
        else $error("pressure level took the unused code");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_opress == r_plevel))
        else $error("result not loaded with the updated pressure level");

endmodule

// ----- sim/tb_memory_budget_pressure_governor.sv -----
module tb_memory_budget_pressure_governor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RES_FRAC_Q16 = 16384;
    localparam int unsigned N_PHASES = 9;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned DRAIN_CYCLES = 320;

    typedef struct {
        logic [37:0] installed_kib;
        logic [37:0] available_kib;
        logic        low_flag;
        logic [47:0] tex_pool;
        logic [47:0] mesh_pool;
    } tick_t;

    typedef struct {
        logic [47:0] tex_grant;
        logic [47:0] mesh_grant;
        logic [1:0]  pressure;
        logic        insert_ok;
        logic [47:0] reserve;
    } grant_t;

    class budget_scoreboard;
        mbpg_pkg::t_cfg cfg;
        logic [1:0]     level;
        grant_t         pending[$];
        int             errors;

        function new();
            cfg.pool_enables      = 2'd3;
            cfg.texture_fraction  = 16'd32768;
            cfg.texture_manual_mb = '0;
            cfg.texture_min_mb    = 28'd1024;
            cfg.mesh_share        = 16'd6554;
            cfg.mesh_manual_mb    = '0;
            cfg.mesh_min_mb       = 28'd256;
            cfg.rsv_mb            = 28'd6144;
            level  = mbpg_pkg::LVL_NORMAL;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                mbpg_pkg::REG_POOL_ENABLES:      cfg.pool_enables = v[1:0];
                mbpg_pkg::REG_TEXTURE_FRACTION:  cfg.texture_fraction = v[15:0];
                mbpg_pkg::REG_TEXTURE_MANUAL_MB: cfg.texture_manual_mb = v[27:0];
                mbpg_pkg::REG_TEXTURE_MIN_MB:    cfg.texture_min_mb = v[27:0];
                mbpg_pkg::REG_MESH_SHARE:        cfg.mesh_share = v[15:0];
                mbpg_pkg::REG_MESH_MANUAL_MB:    cfg.mesh_manual_mb = v[27:0];
                mbpg_pkg::REG_MESH_MIN_MB:       cfg.mesh_min_mb = v[27:0];
                mbpg_pkg::REG_RSV_MB:            cfg.rsv_mb = v[27:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
            logic [127:0] p;
            if (a == 0 || b == 0 || c == 0)
                return 64'd0;
            p = {64'd0, a} * {64'd0, b};
            p = p / {64'd0, c};
            return p[63:0];
        endfunction

        function logic [15:0] clamp16(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function logic [63:0] target_bytes(bit en, logic [27:0] manual, logic [27:0] fl,
                                           logic [15:0] frac, logic [63:0] usable);
            logic [63:0] d;
            logic [63:0] f;
            if (!en || usable == 0)
                return 64'd0;
            d = manual != 0 ? {36'd0, manual} << 20 : (usable * {48'd0, frac}) >> 16;
            f = {36'd0, fl} << 20;
            if (d < f)
                d = f;
            return d < usable ? d : usable;
        endfunction

        function void note_input(tick_t t);
            logic [63:0] inst, eff, held, abs_f, frac_f, rsv, usable;
            logic [63:0] d_tex, d_mesh, d_total, headroom, combined, tex_b, mesh_b;
            logic [63:0] crit, margin, gib;
            logic [1:0]  nxt;
            grant_t      g;
            gib   = {16'd0, mbpg_pkg::GIB_BYTES};
            inst  = {26'd0, t.installed_kib} << 10;
            eff   = {26'd0, t.available_kib} << 10;
            held  = {16'd0, t.tex_pool} + {16'd0, t.mesh_pool};
            abs_f = {36'd0, cfg.rsv_mb} << 20;
            if (abs_f > inst / 2)
                abs_f = inst / 2;
            frac_f = (inst * 64'(RES_FRAC_Q16)) >> 16;
            rsv    = abs_f > frac_f ? abs_f : frac_f;
            usable = inst > rsv ? inst - rsv : 64'd0;
            d_tex  = target_bytes(cfg.pool_enables[0], cfg.texture_manual_mb,
                                  cfg.texture_min_mb,
                                  clamp16(cfg.texture_fraction, mbpg_pkg::TEX_FRAC_MIN,
                                          mbpg_pkg::TEX_FRAC_MAX),
                                  usable);
            d_mesh = target_bytes(cfg.pool_enables[1], cfg.mesh_manual_mb, cfg.mesh_min_mb,
                                  clamp16(cfg.mesh_share, mbpg_pkg::MESH_FRAC_MIN,
                                          mbpg_pkg::MESH_FRAC_MAX),
                                  usable);
            d_total = d_tex + d_mesh;
            if (d_total > usable) begin
                d_tex   = mul_div(usable, d_tex, d_total);
                d_mesh  = usable - d_tex;
                d_total = usable;
            end
            if (eff >= rsv)
                headroom = held + (eff - rsv);
            else
                headroom = held > rsv - eff ? held - (rsv - eff) : 64'd0;
            combined = d_total < headroom ? d_total : headroom;
            tex_b    = mul_div(combined, d_tex, d_total);
            mesh_b   = combined - tex_b;
            if (!cfg.pool_enables[0]) begin
                tex_b  = 0;
                mesh_b = combined;
            end
            if (!cfg.pool_enables[1]) begin
                mesh_b = 0;
                tex_b  = combined;
            end
            crit   = rsv / 2 > gib ? rsv / 2 : gib;
            margin = rsv / 8 > gib ? rsv / 8 : gib;
            if (t.low_flag || eff < crit)
                nxt = mbpg_pkg::LVL_CRITICAL;
            else if (level == mbpg_pkg::LVL_CRITICAL && eff < crit + margin)
                nxt = mbpg_pkg::LVL_CRITICAL;
            else if (eff < rsv)
                nxt = mbpg_pkg::LVL_SOFT;
            else if (level == mbpg_pkg::LVL_SOFT && eff < rsv + margin)
                nxt = mbpg_pkg::LVL_SOFT;
            else
                nxt = mbpg_pkg::LVL_NORMAL;
            level = nxt;
            g.tex_grant  = tex_b[47:0];
            g.mesh_grant = mesh_b[47:0];
            g.pressure   = nxt;
            g.insert_ok  = nxt == mbpg_pkg::LVL_NORMAL;
            g.reserve    = rsv[47:0];
            pending.push_back(g);
        endfunction

        function void check_result(grant_t r);
            grant_t e;
            if (pending.size() == 0) begin
                $error("unexpected result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.tex_grant !== e.tex_grant) begin
                $error("tex_grant_bytes: expected %0d, got %0d", e.tex_grant, r.tex_grant);
                errors++;
            end
            if (r.mesh_grant !== e.mesh_grant) begin
                $error("mesh_grant_bytes: expected %0d, got %0d", e.mesh_grant, r.mesh_grant);
                errors++;
            end
            if (r.pressure !== e.pressure) begin
                $error("pressure_out: expected %0d, got %0d", e.pressure, r.pressure);
                errors++;
            end
            if (r.insert_ok !== e.insert_ok) begin
                $error("insert_ok: expected %0d, got %0d", e.insert_ok, r.insert_ok);
                errors++;
            end
            if (r.reserve !== e.reserve) begin
                $error("reserve_bytes: expected %0d, got %0d", e.reserve, r.reserve);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [37:0] i_installed_kib;
    logic [37:0] i_effective_available_kib;
    logic        i_system_low_flag;
    logic [47:0] i_texture_pool_bytes;
    logic [47:0] i_mesh_pool_bytes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [47:0] o_tex_grant_bytes;
    logic [47:0] o_mesh_grant_bytes;
    logic [1:0]  o_pressure_out;
    logic        o_insert_ok;
    logic [47:0] o_reserve_bytes;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    budget_scoreboard sb;
    bit calm;

    memory_budget_pressure_governor i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_tick(tick_t t);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_installed_kib           = t.installed_kib;
        i_effective_available_kib = t.available_kib;
        i_system_low_flag         = t.low_flag;
        i_texture_pool_bytes      = t.tex_pool;
        i_mesh_pool_bytes         = t.mesh_pool;
        i_in_valid                = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function tick_t random_tick();
        tick_t t;
        logic [63:0] r;
        r = rand64();
        case ($urandom_range(0, 9))
            0: t.installed_kib = r[37:0];
            1: t.installed_kib = 38'($urandom_range(0, 4096));
            default: t.installed_kib = 38'($urandom_range(1, 1024)) << 20;
        endcase
        r = rand64();
        case ($urandom_range(0, 5))
            0: t.available_kib = r[37:0];
            1: t.available_kib = t.installed_kib;
            default: t.available_kib = 38'(r % ({26'd0, t.installed_kib} / 2 + 1));
        endcase
        t.low_flag = $urandom_range(0, 15) == 0;
        r = rand64();
        t.tex_pool = $urandom_range(0, 3) == 0 ? r[47:0] : 48'(r[35:0]);
        r = rand64();
        t.mesh_pool = $urandom_range(0, 3) == 0 ? r[47:0] : 48'(r[33:0]);
        return t;
    endfunction

    task automatic run_directed();
        tick_t t;
        logic [37:0] inst [6] = '{38'd0, 38'd1, 38'h3F_FFFF_FFFF, 38'd16 << 20,
                                  38'd8 << 20, 38'd64 << 20};
        for (int i = 0; i < 24; i++) begin
            t.installed_kib = inst[i % 6];
            case (i % 4)
                0: t.available_kib = '0;
                1: t.available_kib = '1;
                2: t.available_kib = t.installed_kib >> 1;
                default: t.available_kib = t.installed_kib >> 3;
            endcase
            t.low_flag  = i % 5 == 2;
            t.tex_pool  = i % 3 == 0 ? '1 : (i % 3 == 1 ? '0 : 48'h5555_5555_5555);
            t.mesh_pool = i % 3 == 1 ? '1 : (i % 3 == 2 ? '0 : 48'hAAAA_AAAA_AAAA);
            send_tick(t);
        end
    endtask

    task automatic configure(int unsigned phase);
        logic [31:0] v [8];
        case (phase)
            1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            2: v = '{32'd3, 32'hFFFF, 32'hFFF_FFFF, 32'hFFF_FFFF, 32'hFFFF,
                     32'hFFF_FFFF, 32'hFFF_FFFF, 32'hFFF_FFFF};
            3: v = '{32'd1, 32'd65535, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            4: v = '{32'd2, 32'd0, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd0, 32'd0};
            default: begin
                v[mbpg_pkg::REG_POOL_ENABLES] = $urandom;
                v[mbpg_pkg::REG_TEXTURE_FRACTION] = $urandom;
                v[mbpg_pkg::REG_TEXTURE_MANUAL_MB] = $urandom_range(0, 1) ? 0 :
                                                     $urandom_range(1, 600000);
                v[mbpg_pkg::REG_TEXTURE_MIN_MB] = $urandom_range(0, 200000);
                v[mbpg_pkg::REG_MESH_SHARE] = $urandom;
                v[mbpg_pkg::REG_MESH_MANUAL_MB] = $urandom_range(0, 1) ? 0 :
                                                  $urandom_range(1, 600000);
                v[mbpg_pkg::REG_MESH_MIN_MB] = $urandom_range(0, 100000);
                v[mbpg_pkg::REG_RSV_MB] = $urandom_range(0, 3) == 0 ? $urandom :
                                          $urandom_range(0, 300000);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), v[i]);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_installed_kib = '0;
        i_effective_available_kib = '0;
        i_system_low_flag = 1'b0;
        i_texture_pool_bytes = '0;
        i_mesh_pool_bytes = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (int unsigned p = 1; p <= N_PHASES; p++) begin
            drain();
            configure(p);
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 25 == 0)
                    calm = $urandom_range(0, 3) == 0;
                send_tick(random_tick());
            end
        end
        drain();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        grant_t r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.tex_grant  = o_tex_grant_bytes;
            r.mesh_grant = o_mesh_grant_bytes;
            r.pressure   = o_pressure_out;
            r.insert_ok  = o_insert_ok;
            r.reserve    = o_reserve_bytes;
            sb.check_result(r);
        end
    end
endmodule

// ----- filelist.f -----
hw/rtl/mbpg_pkg.sv
hw/rtl/mbpg_regs.sv
hw/rtl/mbpg_mul.sv
hw/rtl/mbpg_muldiv.sv
hw/rtl/memory_budget_pressure_governor.sv
sim/tb_memory_budget_pressure_governor.sv
